>>> rtl/nme_pkg.sv
// nme_pkg: shared types, constants and helper functions of the numeric mask editor
// used by nme_ctrl, nme_dp and numeric_mask_editor_top; depends on nothing else
`timescale 1ns / 1ps
package nme_pkg;

    localparam int MAX_MASK_DEF = 16;
    localparam int WORK_COLS    = 12;
    localparam int BCD_DIGITS   = 10;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 8;
    // two magnitude bits go through the shift-add-3 converter per cycle
    localparam int CONV_STEPS   = VALUE_W / 2;
    localparam int CONV_CW      = $clog2(CONV_STEPS);
    localparam int COL_W        = $clog2(WORK_COLS);

    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_ZED   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_FORMAT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COMPOSE,
        ST_PRE0,
        ST_PRE1,
        ST_WALK,
        ST_EPRE,
        ST_EMIT
    } nme_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic conv;
        logic compose;
        logic pre0;
        logic pre1;
        logic walk;
        logic epre;
        logic emit;
    } nme_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic walk_done;
        logic emit_done;
        logic out_free;
        logic mask_empty;
    } nme_status_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // one shift-add-3 step: correct every digit, then shift in the next bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage

>>> rtl/numeric_mask_editor_top.sv
// Numeric mask editor: a load transfer (tuser 0) appends one mask character while the mask
// store is not full; a format transfer (tuser 1) converts the signed value by two-bit
// shift-add-3 binary-to-decimal conversion, lays out the 12-column string, primes the mask
// store read port, takes one edit step per mask character through the mask store and reads
// the result store out through the output register, which waits on back-pressure. A format
// on an empty mask produces no transfer. The last character of a field may wait in the
// output register while the next input transfer is taken. Depends on nme_pkg, nme_ctrl and nme_dp.
`timescale 1ns / 1ps
module numeric_mask_editor_top #(
    parameter int MAX_MASK = nme_pkg::MAX_MASK_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nme_pkg::IN_TDATA_W-1:0]      s_tdata,   // mask_char[7:0], value[39:8]
    input  logic                                s_tuser,   // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nme_pkg::OUT_TDATA_W-1:0]     m_tdata,   // out_char[7:0]
    output logic                                m_tlast
);
    import nme_pkg::*;

    nme_cmd_t    cmd;
    nme_status_t status;

    nme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nme_dp #(
        .MAX_MASK (MAX_MASK)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mask_char (s_tdata[CHAR_W-1:0]),
        .in_value     (s_tdata[CHAR_W +: VALUE_W]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_char     (m_tdata),
        .out_last     (m_tlast)
    );

endmodule

>>> rtl/nme_ctrl.sv
// nme_ctrl: sequencing state machine of the numeric mask editor
// depends on nme_pkg; drives nme_dp through the command struct
`timescale 1ns / 1ps
module nme_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_kind,
    output logic                 in_ready,
    input  nme_pkg::nme_status_t status,
    output nme_pkg::nme_cmd_t    cmd
);
    import nme_pkg::*;

    nme_state_t state_reg;
    nme_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (!status.mask_empty)
                    begin
                        // a format with an empty mask gives nothing
                        cmd.start  = 1'b1;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_COMPOSE;
                end
            end
            ST_COMPOSE:
            begin
                cmd.compose = 1'b1;
                state_next  = ST_PRE0;
            end
            ST_PRE0:
            begin
                cmd.pre0   = 1'b1;
                state_next = ST_PRE1;
            end
            ST_PRE1:
            begin
                cmd.pre1   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_EPRE;
                end
            end
            ST_EPRE:
            begin
                cmd.epre   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.out_free && status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/nme_dp.sv
// nme_dp: datapath of the numeric mask editor: mask store, decimal converter,
// edit walker, result store and output register; depends on nme_pkg
`timescale 1ns / 1ps
module nme_dp #(
    parameter int MAX_MASK = nme_pkg::MAX_MASK_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [nme_pkg::CHAR_W-1:0]       in_mask_char,
    input  logic signed [nme_pkg::VALUE_W-1:0] in_value,
    input  nme_pkg::nme_cmd_t                cmd,
    output nme_pkg::nme_status_t             status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [nme_pkg::CHAR_W-1:0]       out_char,
    output logic                             out_last
);
    import nme_pkg::*;

    localparam int AW = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
    localparam int CW = $clog2(MAX_MASK + 1);
    localparam logic [CW-1:0] MASK_FULL = CW'(MAX_MASK);
    localparam logic [AW-1:0] ONE_A = AW'(1);
    localparam logic [AW-1:0] TWO_A = AW'(2);
    localparam logic [COL_W-1:0] RP_START = COL_W'(WORK_COLS - 1);

    logic [CHAR_W-1:0] mask_mem [MAX_MASK];
    logic [CHAR_W-1:0] res_mem [MAX_MASK];

    logic [CW-1:0]      mask_count_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic               neg_reg;
    logic [VALUE_W-1:0] mag_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [CONV_CW-1:0] conv_cnt_reg;
    logic [CHAR_W-1:0]  work_reg [WORK_COLS];
    logic [CHAR_W-1:0]  work_next [WORK_COLS];
    logic [COL_W-1:0]   rp_reg;
    logic [COL_W-1:0]   rp_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      last_reg;
    logic [AW-1:0]      ptr_reg;
    logic [CHAR_W-1:0]  cur_reg;
    logic [CHAR_W-1:0]  mrd_reg;
    logic [CHAR_W-1:0]  rrd_reg;
    logic               prev_digit_reg;

    logic [CW-1:0]      count_m1;
    logic               mrd_en;
    logic [AW-1:0]      mrd_addr;
    logic               rrd_en;
    logic [AW-1:0]      rrd_addr;
    logic               out_load;
    logic [3:0]         ndig;
    logic [BCD_W+7:0]   bcd_ext;
    logic [CHAR_W-1:0]  s_char;
    logic [CHAR_W-1:0]  res_next;
    logic               left_nine;

    assign count_m1 = mask_count_reg - CW'(1);
    assign out_load = cmd.emit && status.out_free;

    assign status.conv_done  = (conv_cnt_reg == CONV_CW'(CONV_STEPS - 1));
    assign status.walk_done  = (idx_reg == '0);
    assign status.emit_done  = (ptr_reg == last_reg);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.mask_empty = (mask_count_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // mask store read port: one entry ahead of the walk for the comma look-left
    always_comb
    begin
        mrd_en   = 1'b0;
        mrd_addr = idx_reg;
        if (cmd.pre0)
        begin
            mrd_en   = 1'b1;
            mrd_addr = count_m1[AW-1:0];
        end
        else if (cmd.pre1)
        begin
            mrd_en   = (idx_reg != '0);
            mrd_addr = idx_reg - ONE_A;
        end
        else if (cmd.walk)
        begin
            mrd_en   = (idx_reg > ONE_A);
            mrd_addr = idx_reg - TWO_A;
        end
    end

    always_comb
    begin
        rrd_en   = 1'b0;
        rrd_addr = ptr_reg + ONE_A;
        if (cmd.epre)
        begin
            rrd_en   = 1'b1;
            rrd_addr = '0;
        end
        else if (out_load && !status.emit_done)
        begin
            rrd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (mask_count_reg < MASK_FULL))
        begin
            mask_mem[mask_count_reg[AW-1:0]] <= in_mask_char;
        end
        if (mrd_en)
        begin
            mrd_reg <= mask_mem[mrd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            res_mem[idx_reg] <= res_next;
        end
        if (rrd_en)
        begin
            rrd_reg <= res_mem[rrd_addr];
        end
    end

    // right-aligned decimal string: digits, then '-' if negative, spaces left of it
    always_comb
    begin
        bcd_ext = {8'd0, bcd_reg};
        ndig    = 4'd1;
        for (int j = 0; j < BCD_DIGITS; j++)
        begin
            if (bcd_reg[4*j +: 4] != 4'd0)
            begin
                ndig = 4'(j + 1);
            end
        end
        for (int c = 0; c < WORK_COLS; c++)
        begin
            work_next[c] = CH_SPACE;
            if ((WORK_COLS - 1 - c) < int'(ndig))
            begin
                work_next[c] = CH_ZERO + {4'd0, bcd_ext[4*(WORK_COLS-1-c) +: 4]};
            end
            else if (neg_reg && ((WORK_COLS - 1 - c) == int'(ndig)))
            begin
                work_next[c] = CH_MINUS;
            end
        end
    end

    // one edit step for mask position idx_reg
    always_comb
    begin
        s_char    = work_reg[rp_reg];
        left_nine = (idx_reg != '0) && (mrd_reg == CH_NINE);
        rp_next   = rp_reg;
        case (cur_reg)
            CH_NINE:
            begin
                if ((s_char == CH_SPACE) || (s_char == CH_MINUS))
                begin
                    res_next = CH_ZERO;
                end
                else
                begin
                    res_next = s_char;
                    if (rp_reg != '0)
                    begin
                        rp_next = rp_reg - COL_W'(1);
                    end
                end
            end
            CH_ZED:
            begin
                if (s_char == CH_SPACE)
                begin
                    res_next = CH_SPACE;
                end
                else
                begin
                    res_next = s_char;
                    if (rp_reg != '0)
                    begin
                        rp_next = rp_reg - COL_W'(1);
                    end
                end
            end
            CH_DOT:
            begin
                res_next = CH_DOT;
            end
            CH_COMMA:
            begin
                res_next = CH_SPACE;
                if (prev_digit_reg && ((s_char != CH_SPACE) || left_nine))
                begin
                    res_next = CH_COMMA;
                end
            end
            default:
            begin
                res_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load && (mask_count_reg < MASK_FULL))
            begin
                mask_count_reg <= mask_count_reg + CW'(1);
            end
            else if (cmd.walk && status.walk_done)
            begin
                mask_count_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            neg_reg      <= in_value[VALUE_W-1];
            mag_reg      <= in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
            bcd_reg      <= '0;
            conv_cnt_reg <= '0;
        end
        if (cmd.conv)
        begin
            bcd_reg      <= dd_step(dd_step(bcd_reg, mag_reg[VALUE_W-1]), mag_reg[VALUE_W-2]);
            mag_reg      <= {mag_reg[VALUE_W-3:0], 2'b00};
            conv_cnt_reg <= conv_cnt_reg + CONV_CW'(1);
        end
        if (cmd.compose)
        begin
            work_reg <= work_next;
            rp_reg   <= RP_START;
        end
        if (cmd.pre0)
        begin
            idx_reg  <= count_m1[AW-1:0];
            last_reg <= count_m1[AW-1:0];
        end
        if (cmd.pre1)
        begin
            cur_reg        <= mrd_reg;
            prev_digit_reg <= 1'b0;
        end
        if (cmd.walk)
        begin
            cur_reg        <= mrd_reg;
            prev_digit_reg <= is_digit(res_next);
            rp_reg         <= rp_next;
            idx_reg        <= idx_reg - ONE_A;
        end
        if (cmd.epre)
        begin
            ptr_reg <= '0;
        end
        if (out_load)
        begin
            out_char_reg <= rrd_reg;
            out_last_reg <= status.emit_done;
            ptr_reg      <= ptr_reg + ONE_A;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mask_count_reg <= MASK_FULL)
        else $error("mask count beyond store depth");

    a_mask_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && status.walk_done) |=> (mask_count_reg == '0))
        else $error("mask store not emptied after walk");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && status.emit_done) |=> (out_valid_reg && out_last_reg))
        else $error("final character not flagged last");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load) |-> !(cmd.walk || cmd.emit || cmd.conv))
        else $error("mask load during format");
`endif

endmodule
